>>> hdl/spgs_pkg.sv
package spgs_pkg;

   // frame geometry, fixes the reset position of the running peak and gaze
   localparam int FrameWidth  = 320;
   localparam int FrameHeight = 240;

   localparam logic [9:0]         RUN_X_RST  = 10'(FrameWidth / 2);
   localparam logic [9:0]         RUN_Y_RST  = 10'(FrameHeight / 2);
   localparam logic signed [10:0] GAZE_X_RST = 11'(FrameWidth / 2);
   localparam logic signed [10:0] GAZE_Y_RST = 11'(FrameHeight / 2);
   localparam logic signed [10:0] HELD_XY_RST = -11'sd1;
   localparam logic signed [16:0] TRK_LEVEL_RST = -17'sd256;

   // held peak must exceed this (about 0.01 in 8.8) to give a saccade target
   localparam logic [15:0] LEVEL_MIN = 16'd2;

   // request modes
   localparam logic [1:0] MODE_PIXEL   = 2'd0;
   localparam logic [1:0] MODE_TRACKER = 2'd1;
   localparam logic [1:0] MODE_TICK    = 2'd2;

   // register indexes
   localparam logic [3:0] REG_THR_DIFF = 4'd0;
   localparam logic [3:0] REG_THR_DIST = 4'd1;
   localparam logic [3:0] REG_DELAY    = 4'd2;
   localparam logic [3:0] REG_LEFT     = 4'd3;
   localparam logic [3:0] REG_RIGHT    = 4'd4;
   localparam logic [3:0] REG_TOP      = 4'd5;
   localparam logic [3:0] REG_BOTTOM   = 4'd6;
   localparam logic [3:0] REG_INHIBIT  = 4'd7;

   // register reset values
   localparam logic [15:0] THR_DIFF_RST = 16'd5120;
   localparam logic [19:0] THR_DIST_SQ_RST = 20'd1600;
   localparam logic [15:0] DELAY_RST    = 16'd100;
   localparam logic [10:0] LEFT_RST     = 11'd0;
   localparam logic [10:0] RIGHT_RST    = 11'd320;
   localparam logic [10:0] TOP_RST      = 11'd0;
   localparam logic [10:0] BOTTOM_RST   = 11'd240;

   // tick queue geometry
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = QPtrW + 1;

   // source codes
   localparam logic SRC_PEAK    = 1'b0;
   localparam logic SRC_TRACKER = 1'b1;

   typedef struct packed {
      logic [15:0] thr_diff;
      logic [19:0] thr_dist_sq;
   } cfg_front_type;

   typedef struct packed {
      logic [15:0] delay;
      logic [10:0] limit_left;
      logic [10:0] limit_right;
      logic [10:0] limit_top;
      logic [10:0] limit_bottom;
      logic        inhibit;
   } cfg_back_type;

   // snapshot of the front state taken with each update tick
   typedef struct packed {
      logic [15:0]        held_value;
      logic signed [10:0] held_x;
      logic signed [10:0] held_y;
      logic signed [15:0] trk_x;
      logic signed [15:0] trk_y;
      logic signed [16:0] trk_level;
   } tick_type;

endpackage

>>> hdl/saliency_peak_gaze_selector_core.sv
// Saliency peak gaze selector.
// Request channel (req_valid/req_ready): one request per cycle, chosen by
// req_mode: a saliency pixel, a tracker report or an update tick. Pixels and
// tracker reports are absorbed in the front part in the cycle they are taken
// and never give a result. Each update tick is queued with a snapshot of the
// held peak and tracker target, and the back part turns it into at most one
// result on the rsp_ channel (valid/ready).
// Throughput: one request per cycle, set by the front part (peak compare and
// squared-distance test unregistered) and one tick per cycle in the back part.
// Path: a tick taken on the request channel is written into the four-entry
// tick queue and, once the output register is free, moved into it; the result
// is driven from the output register.
// When rsp_ready is low the result stays in the output register, ticks collect
// in the queue, and req_ready drops only once the queue is full; pixels and
// tracker reports then wait too.
// Reset (synchronous, active high) sets state registers at once, not queue
// entries or result payload: no clearing pass is needed. Configuration (csr_)
// must be written while no request is in flight; the block does not check it.
module saliency_peak_gaze_selector_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [3:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [9:0]          req_pixel_x,
   input  logic [9:0]          req_pixel_y,
   input  logic [15:0]         req_salience,
   input  logic                req_frame_last,
   input  logic signed [15:0]  req_tracker_pos_x,
   input  logic signed [15:0]  req_tracker_pos_y,
   input  logic signed [16:0]  req_tracker_level,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_source,
   output logic signed [15:0]  rsp_target_x,
   output logic signed [15:0]  rsp_target_y,
   output logic signed [16:0]  rsp_target_level,
   output logic [15:0]         rsp_saccade_count
);

   logic [15:0] thr_diff_ff;
   logic [19:0] thr_dist_sq_ff;
   logic [19:0] thr_dist_sq_in;
   logic [15:0] delay_ff;
   logic [10:0] left_ff;
   logic [10:0] right_ff;
   logic [10:0] top_ff;
   logic [10:0] bottom_ff;
   logic        inhibit_ff;

   spgs_pkg::cfg_front_type cfg_front;
   spgs_pkg::cfg_back_type  cfg_back;
   spgs_pkg::tick_type      push_data;
   spgs_pkg::tick_type      head_data;
   logic                    q_push;
   logic                    q_pop;
   logic                    q_full;
   logic                    q_valid;

   // distance threshold kept squared, computed on the write
   assign thr_dist_sq_in = csr_wdata[9:0] * csr_wdata[9:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_diff_ff    <= spgs_pkg::THR_DIFF_RST;
         thr_dist_sq_ff <= spgs_pkg::THR_DIST_SQ_RST;
         delay_ff       <= spgs_pkg::DELAY_RST;
         left_ff        <= spgs_pkg::LEFT_RST;
         right_ff       <= spgs_pkg::RIGHT_RST;
         top_ff         <= spgs_pkg::TOP_RST;
         bottom_ff      <= spgs_pkg::BOTTOM_RST;
         inhibit_ff     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            spgs_pkg::REG_THR_DIFF: thr_diff_ff    <= csr_wdata;
            spgs_pkg::REG_THR_DIST: thr_dist_sq_ff <= thr_dist_sq_in;
            spgs_pkg::REG_DELAY:    delay_ff       <= csr_wdata;
            spgs_pkg::REG_LEFT:     left_ff        <= csr_wdata[10:0];
            spgs_pkg::REG_RIGHT:    right_ff       <= csr_wdata[10:0];
            spgs_pkg::REG_TOP:      top_ff         <= csr_wdata[10:0];
            spgs_pkg::REG_BOTTOM:   bottom_ff      <= csr_wdata[10:0];
            spgs_pkg::REG_INHIBIT:  inhibit_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg_front.thr_diff     = thr_diff_ff;
   assign cfg_front.thr_dist_sq  = thr_dist_sq_ff;
   assign cfg_back.delay         = delay_ff;
   assign cfg_back.limit_left    = left_ff;
   assign cfg_back.limit_right   = right_ff;
   assign cfg_back.limit_top     = top_ff;
   assign cfg_back.limit_bottom  = bottom_ff;
   assign cfg_back.inhibit       = inhibit_ff;

   // front: peak tracking, tracker store, tick dispatch
   spgs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_salience      (req_salience),
      .req_frame_last    (req_frame_last),
      .req_tracker_pos_x (req_tracker_pos_x),
      .req_tracker_pos_y (req_tracker_pos_y),
      .req_tracker_level (req_tracker_level),
      .cfg               (cfg_front),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (push_data)
   );

   // tick queue
   spgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (head_data)
   );

   // back: gaze selection and result register
   spgs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (head_data),
      .q_pop             (q_pop),
      .cfg               (cfg_back),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_source        (rsp_source),
      .rsp_target_x      (rsp_target_x),
      .rsp_target_y      (rsp_target_y),
      .rsp_target_level  (rsp_target_level),
      .rsp_saccade_count (rsp_saccade_count)
   );

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a tick is only queued when there is room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("tick queue overflow");

   // a stalled result blocks the back part
   a_stall_holds_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !q_pop)
      else $error("tick taken while result stalled");

   // saccade targets only come from a live peak
   a_peak_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_source == spgs_pkg::SRC_PEAK))
      |-> (rsp_target_level > $signed({1'b0, spgs_pkg::LEVEL_MIN})))
      else $error("saccade target below minimum level");

endmodule

>>> hdl/spgs_front.sv
module spgs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic [9:0]                  req_pixel_x,
   input  logic [9:0]                  req_pixel_y,
   input  logic [15:0]                 req_salience,
   input  logic                        req_frame_last,
   input  logic signed [15:0]          req_tracker_pos_x,
   input  logic signed [15:0]          req_tracker_pos_y,
   input  logic signed [16:0]          req_tracker_level,
   input  spgs_pkg::cfg_front_type     cfg,
   input  logic                        q_full,
   output logic                        q_push,
   output spgs_pkg::tick_type          q_data
);

   logic [15:0]        run_value_ff, run_value_in;
   logic [9:0]         run_x_ff, run_x_in;
   logic [9:0]         run_y_ff, run_y_in;
   logic [15:0]        held_value_ff, held_value_in;
   logic signed [10:0] held_x_ff, held_x_in;
   logic signed [10:0] held_y_ff, held_y_in;
   logic signed [15:0] trk_x_ff, trk_x_in;
   logic signed [15:0] trk_y_ff, trk_y_in;
   logic signed [16:0] trk_level_ff, trk_level_in;

   logic               accept;
   logic               cand_take;
   logic [15:0]        cand_value;
   logic [9:0]         cand_x;
   logic [9:0]         cand_y;
   logic [15:0]        dv_abs;
   logic signed [11:0] dx;
   logic signed [11:0] dy;
   logic signed [23:0] dx_prod;
   logic signed [23:0] dy_prod;
   logic [21:0]        dist_sq;
   logic               replace;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // running peak including the current pixel
   assign cand_take  = req_salience > run_value_ff;
   assign cand_value = cand_take ? req_salience : run_value_ff;
   assign cand_x     = cand_take ? req_pixel_x : run_x_ff;
   assign cand_y     = cand_take ? req_pixel_y : run_y_ff;

   // distance and value change against the held peak
   assign dv_abs  = (held_value_ff >= cand_value) ? (held_value_ff - cand_value)
                                                   : (cand_value - held_value_ff);
   assign dx      = $signed({2'b00, cand_x}) - {held_x_ff[10], held_x_ff};
   assign dy      = $signed({2'b00, cand_y}) - {held_y_ff[10], held_y_ff};
   assign dx_prod = dx * dx;
   assign dy_prod = dy * dy;
   assign dist_sq = {1'b0, dx_prod[20:0]} + {1'b0, dy_prod[20:0]};
   assign replace = (dv_abs >= cfg.thr_diff) && (dist_sq >= {2'b00, cfg.thr_dist_sq});

   // next state
   always_comb begin
      run_value_in  = run_value_ff;
      run_x_in      = run_x_ff;
      run_y_in      = run_y_ff;
      held_value_in = held_value_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      trk_x_in      = trk_x_ff;
      trk_y_in      = trk_y_ff;
      trk_level_in  = trk_level_ff;
      if (accept) begin
         case (req_mode)
            spgs_pkg::MODE_PIXEL: begin
               if (req_frame_last) begin
                  run_value_in = '0;
                  run_x_in     = spgs_pkg::RUN_X_RST;
                  run_y_in     = spgs_pkg::RUN_Y_RST;
                  if (replace) begin
                     held_value_in = cand_value;
                     held_x_in     = $signed({1'b0, cand_x});
                     held_y_in     = $signed({1'b0, cand_y});
                  end
               end else begin
                  run_value_in = cand_value;
                  run_x_in     = cand_x;
                  run_y_in     = cand_y;
               end
            end
            spgs_pkg::MODE_TRACKER: begin
               trk_x_in     = req_tracker_pos_x;
               trk_y_in     = req_tracker_pos_y;
               trk_level_in = req_tracker_level;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= '0;
         run_x_ff      <= spgs_pkg::RUN_X_RST;
         run_y_ff      <= spgs_pkg::RUN_Y_RST;
         held_value_ff <= '0;
         held_x_ff     <= spgs_pkg::HELD_XY_RST;
         held_y_ff     <= spgs_pkg::HELD_XY_RST;
         trk_x_ff      <= '0;
         trk_y_ff      <= '0;
         trk_level_ff  <= spgs_pkg::TRK_LEVEL_RST;
      end else begin
         run_value_ff  <= run_value_in;
         run_x_ff      <= run_x_in;
         run_y_ff      <= run_y_in;
         held_value_ff <= held_value_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         trk_x_ff      <= trk_x_in;
         trk_y_ff      <= trk_y_in;
         trk_level_ff  <= trk_level_in;
      end
   end

   // ticks go to the back part with the state they must see
   assign q_push           = accept && (req_mode == spgs_pkg::MODE_TICK);
   assign q_data.held_value = held_value_ff;
   assign q_data.held_x     = held_x_ff;
   assign q_data.held_y     = held_y_ff;
   assign q_data.trk_x      = trk_x_ff;
   assign q_data.trk_y      = trk_y_ff;
   assign q_data.trk_level  = trk_level_ff;

endmodule

>>> hdl/spgs_queue.sv
module spgs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  spgs_pkg::tick_type  push_data,
   input  logic                pop,
   output logic                full,
   output logic                valid,
   output spgs_pkg::tick_type  head
);

   spgs_pkg::tick_type               entries_ff [spgs_pkg::QDepth];
   logic [spgs_pkg::QPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [spgs_pkg::QPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [spgs_pkg::QCntW-1:0]       count_ff, count_in;

   assign full  = (count_ff == spgs_pkg::QCntW'(spgs_pkg::QDepth));
   assign valid = (count_ff != '0);
   assign head  = entries_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/spgs_back.sv
module spgs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  spgs_pkg::tick_type       q_data,
   output logic                     q_pop,
   input  spgs_pkg::cfg_back_type   cfg,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_source,
   output logic signed [15:0]       rsp_target_x,
   output logic signed [15:0]       rsp_target_y,
   output logic signed [16:0]       rsp_target_level,
   output logic [15:0]              rsp_saccade_count
);

   logic signed [10:0] gaze_x_ff, gaze_x_in;
   logic signed [10:0] gaze_y_ff, gaze_y_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic [15:0]        count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_source_ff, out_source_in;
   logic signed [15:0] out_x_ff, out_x_in;
   logic signed [15:0] out_y_ff, out_y_in;
   logic signed [16:0] out_level_ff, out_level_in;
   logic [15:0]        out_count_ff, out_count_in;

   logic               slot_free;
   logic [15:0]        elapsed_inc;
   logic               peak_path;
   logic               peak_live;
   logic signed [11:0] hx;
   logic signed [11:0] hy;
   logic               in_limits;
   logic               jump;
   logic               moved;
   logic [15:0]        count_next;

   // the output register takes a new result when empty or being drained
   assign slot_free = !out_valid_ff || rsp_ready;
   assign q_pop     = q_valid && slot_free;

   // decision for the tick at the head of the queue
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : (elapsed_ff + 16'd1);
   assign peak_path   = $signed({q_data.trk_level[16], q_data.trk_level})
                        < $signed({2'b00, q_data.held_value});
   assign peak_live   = q_data.held_value > spgs_pkg::LEVEL_MIN;
   assign hx          = {q_data.held_x[10], q_data.held_x};
   assign hy          = {q_data.held_y[10], q_data.held_y};
   assign in_limits   = (hx < $signed({1'b0, cfg.limit_right}))
                        && (hx > $signed({1'b0, cfg.limit_left}))
                        && (hy > $signed({1'b0, cfg.limit_top}))
                        && (hy < $signed({1'b0, cfg.limit_bottom}));
   assign jump        = (elapsed_inc > cfg.delay) && in_limits;
   assign moved       = jump && ((q_data.held_x != gaze_x_ff) || (q_data.held_y != gaze_y_ff));
   assign count_next  = count_ff + {15'd0, moved};

   // next state and result
   always_comb begin
      gaze_x_in     = gaze_x_ff;
      gaze_y_in     = gaze_y_ff;
      elapsed_in    = elapsed_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_source_in = out_source_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_level_in  = out_level_ff;
      out_count_in  = out_count_ff;
      if (q_pop) begin
         elapsed_in = elapsed_inc;
         if (peak_path) begin
            if (peak_live) begin
               if (jump) begin
                  gaze_x_in  = q_data.held_x;
                  gaze_y_in  = q_data.held_y;
                  elapsed_in = '0;
               end
               count_in = count_next;
               if (!cfg.inhibit) begin
                  out_valid_in  = 1'b1;
                  out_source_in = spgs_pkg::SRC_PEAK;
                  out_x_in      = jump ? 16'(q_data.held_x) : 16'(gaze_x_ff);
                  out_y_in      = jump ? 16'(q_data.held_y) : 16'(gaze_y_ff);
                  out_level_in  = $signed({1'b0, q_data.held_value});
                  out_count_in  = count_next;
               end
            end
         end else begin
            out_valid_in  = 1'b1;
            out_source_in = spgs_pkg::SRC_TRACKER;
            out_x_in      = q_data.trk_x;
            out_y_in      = q_data.trk_y;
            out_level_in  = q_data.trk_level;
            out_count_in  = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gaze_x_ff    <= spgs_pkg::GAZE_X_RST;
         gaze_y_ff    <= spgs_pkg::GAZE_Y_RST;
         elapsed_ff   <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         gaze_x_ff    <= gaze_x_in;
         gaze_y_ff    <= gaze_y_in;
         elapsed_ff   <= elapsed_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_source_ff <= out_source_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_level_ff  <= out_level_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_source        = out_source_ff;
   assign rsp_target_x      = out_x_ff;
   assign rsp_target_y      = out_y_ff;
   assign rsp_target_level  = out_level_ff;
   assign rsp_saccade_count = out_count_ff;

endmodule

>>> verif/saliency_peak_gaze_selector_core_test.sv
module saliency_peak_gaze_selector_core_test;

   localparam int FRAME_W = 320;
   localparam int FRAME_H = 240;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PERCENT = 27;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [3:0] REG_UNMAPPED = 4'd15;

   typedef struct {
      logic [1:0]         mode;
      logic [9:0]         px;
      logic [9:0]         py;
      logic [15:0]        sal;
      logic               frame_end;
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      logic signed [16:0] tl;
   } gaze_request_type;

   typedef struct {
      logic               source;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [16:0] level;
      logic [15:0]        count;
   } gaze_target_type;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [3:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_mode;
   logic [9:0]         req_pixel_x;
   logic [9:0]         req_pixel_y;
   logic [15:0]        req_salience;
   logic               req_frame_last;
   logic signed [15:0] req_tracker_pos_x;
   logic signed [15:0] req_tracker_pos_y;
   logic signed [16:0] req_tracker_level;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_source;
   logic signed [15:0] rsp_target_x;
   logic signed [15:0] rsp_target_y;
   logic signed [16:0] rsp_target_level;
   logic [15:0]        rsp_saccade_count;

   // settings as the block should hold them
   logic [15:0] set_thr_diff;
   logic [9:0]  set_thr_dist;
   logic [15:0] set_delay;
   logic [10:0] set_left, set_right, set_top, set_bottom;
   logic        set_inhibit;

   // selector state
   logic [15:0]        peak_run_value;
   logic [9:0]         peak_run_x, peak_run_y;
   logic [15:0]        peak_held_value;
   int                 peak_held_x, peak_held_y;
   logic signed [15:0] trk_x, trk_y;
   logic signed [16:0] trk_level;
   int                 gaze_x, gaze_y;
   int                 ticks_since_jump;
   logic [15:0]        saccade_total;

   gaze_target_type expected_targets[$];
   int  failures;
   int  targets_checked;
   int  mode_counts[4];
   int  cycles;
   bit  steady;

   saliency_peak_gaze_selector_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_salience      (req_salience),
      .req_frame_last    (req_frame_last),
      .req_tracker_pos_x (req_tracker_pos_x),
      .req_tracker_pos_y (req_tracker_pos_y),
      .req_tracker_level (req_tracker_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_source        (rsp_source),
      .rsp_target_x      (rsp_target_x),
      .rsp_target_y      (rsp_target_y),
      .rsp_target_level  (rsp_target_level),
      .rsp_saccade_count (rsp_saccade_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // result checking, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin : check_results
      gaze_target_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_targets.size() == 0) begin
            $error("unexpected target: source %0d x %0d y %0d level %0d count %0d",
                   rsp_source, rsp_target_x, rsp_target_y, rsp_target_level,
                   rsp_saccade_count);
            failures++;
         end else begin
            want = expected_targets.pop_front();
            targets_checked++;
            if (rsp_source !== want.source) begin
               $error("source: expected %0d, got %0d", want.source, rsp_source);
               failures++;
            end
            if (rsp_target_x !== want.x) begin
               $error("target_x: expected %0d, got %0d", want.x, rsp_target_x);
               failures++;
            end
            if (rsp_target_y !== want.y) begin
               $error("target_y: expected %0d, got %0d", want.y, rsp_target_y);
               failures++;
            end
            if (rsp_target_level !== want.level) begin
               $error("target_level: expected %0d, got %0d", want.level, rsp_target_level);
               failures++;
            end
            if (rsp_saccade_count !== want.count) begin
               $error("saccade_count: expected %0d, got %0d", want.count,
                      rsp_saccade_count);
               failures++;
            end
         end
      end
   end

   function automatic void reset_selector();
      set_thr_diff     = 16'd5120;
      set_thr_dist     = 10'd40;
      set_delay        = 16'd100;
      set_left         = 11'd0;
      set_right        = 11'd320;
      set_top          = 11'd0;
      set_bottom       = 11'd240;
      set_inhibit      = 1'b0;
      peak_run_value   = '0;
      peak_run_x       = 10'(FRAME_W / 2);
      peak_run_y       = 10'(FRAME_H / 2);
      peak_held_value  = '0;
      peak_held_x      = -1;
      peak_held_y      = -1;
      trk_x            = '0;
      trk_y            = '0;
      trk_level        = -17'sd256;
      gaze_x           = FRAME_W / 2;
      gaze_y           = FRAME_H / 2;
      ticks_since_jump = 0;
      saccade_total    = '0;
   endfunction

   function automatic void apply_register(input logic [3:0] idx, input logic [15:0] data);
      case (idx)
         spgs_pkg::REG_THR_DIFF: set_thr_diff = data;
         spgs_pkg::REG_THR_DIST: set_thr_dist = data[9:0];
         spgs_pkg::REG_DELAY:    set_delay    = data;
         spgs_pkg::REG_LEFT:     set_left     = data[10:0];
         spgs_pkg::REG_RIGHT:    set_right    = data[10:0];
         spgs_pkg::REG_TOP:      set_top      = data[10:0];
         spgs_pkg::REG_BOTTOM:   set_bottom   = data[10:0];
         spgs_pkg::REG_INHIBIT:  set_inhibit  = data[0];
         default: ;
      endcase
   endfunction

   // peak tracking, tracker capture and target selection for one request
   function automatic void predict_selection(input gaze_request_type r);
      longint dv, dx, dy, td;
      int old_x, old_y;
      gaze_target_type t;
      case (r.mode)
         spgs_pkg::MODE_PIXEL: begin
            if (r.sal > peak_run_value) begin
               peak_run_value = r.sal;
               peak_run_x = r.px;
               peak_run_y = r.py;
            end
            if (r.frame_end) begin
               dv = longint'(peak_held_value) - longint'(peak_run_value);
               dx = longint'(peak_run_x) - longint'(peak_held_x);
               dy = longint'(peak_run_y) - longint'(peak_held_y);
               td = longint'(set_thr_dist);
               if (dv < 0) dv = -dv;
               if (dv >= longint'(set_thr_diff) && dx * dx + dy * dy >= td * td) begin
                  peak_held_value = peak_run_value;
                  peak_held_x = int'(peak_run_x);
                  peak_held_y = int'(peak_run_y);
               end
               peak_run_value = '0;
               peak_run_x = 10'(FRAME_W / 2);
               peak_run_y = 10'(FRAME_H / 2);
            end
         end
         spgs_pkg::MODE_TRACKER: begin
            trk_x = r.tx;
            trk_y = r.ty;
            trk_level = r.tl;
         end
         spgs_pkg::MODE_TICK: begin
            if (ticks_since_jump < 65535) ticks_since_jump++;
            if (int'(trk_level) < int'(peak_held_value)) begin
               // saccade path, silent while the held peak is negligible
               if (peak_held_value > spgs_pkg::LEVEL_MIN) begin
                  old_x = gaze_x;
                  old_y = gaze_y;
                  if (ticks_since_jump > int'(set_delay) &&
                      peak_held_x < int'(set_right) && peak_held_x > int'(set_left) &&
                      peak_held_y > int'(set_top) && peak_held_y < int'(set_bottom)) begin
                     gaze_x = peak_held_x;
                     gaze_y = peak_held_y;
                     ticks_since_jump = 0;
                  end
                  if (gaze_x != old_x || gaze_y != old_y) saccade_total++;
                  if (!set_inhibit) begin
                     t.source = spgs_pkg::SRC_PEAK;
                     t.x      = 16'(gaze_x);
                     t.y      = 16'(gaze_y);
                     t.level  = 17'(peak_held_value);
                     t.count  = saccade_total;
                     expected_targets.push_back(t);
                  end
               end
            end else begin
               t.source = spgs_pkg::SRC_TRACKER;
               t.x      = trk_x;
               t.y      = trk_y;
               t.level  = trk_level;
               t.count  = saccade_total;
               expected_targets.push_back(t);
            end
         end
         default: ;
      endcase
   endfunction

   // one request, held until taken; called and returning at a rising edge
   task automatic send_request(input gaze_request_type r);
      bit taken;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_mode          <= r.mode;
      req_pixel_x       <= r.px;
      req_pixel_y       <= r.py;
      req_salience      <= r.sal;
      req_frame_last    <= r.frame_end;
      req_tracker_pos_x <= r.tx;
      req_tracker_pos_y <= r.ty;
      req_tracker_level <= r.tl;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      mode_counts[r.mode]++;
      predict_selection(r);
   endtask

   // sender pauses until every target is back and the tick queue has emptied
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_targets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [3:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      apply_register(idx, data);
   endtask

   task automatic load_settings(input logic [15:0] diff, input logic [9:0] distance,
                                input logic [15:0] delay, input logic [10:0] left,
                                input logic [10:0] right, input logic [10:0] top,
                                input logic [10:0] bottom, input logic inhibit);
      write_register(spgs_pkg::REG_THR_DIFF, diff);
      write_register(spgs_pkg::REG_THR_DIST, 16'(distance));
      write_register(spgs_pkg::REG_DELAY, delay);
      write_register(spgs_pkg::REG_LEFT, 16'(left));
      write_register(spgs_pkg::REG_RIGHT, 16'(right));
      write_register(spgs_pkg::REG_TOP, 16'(top));
      write_register(spgs_pkg::REG_BOTTOM, 16'(bottom));
      write_register(spgs_pkg::REG_INHIBIT, 16'(inhibit));
   endtask

   task automatic load_random_settings();
      load_settings(16'($urandom_range(0, 8000)), 10'($urandom_range(0, 60)),
                    16'($urandom_range(0, 6)),
                    11'($urandom_range(0, 150)), 11'($urandom_range(200, 1024)),
                    11'($urandom_range(0, 100)), 11'($urandom_range(150, 1024)),
                    $urandom_range(99) < 15);
   endtask

   function automatic gaze_request_type make_request(
         input logic [1:0] mode, input logic [9:0] px, input logic [9:0] py,
         input logic [15:0] sal, input logic frame_end, input logic signed [15:0] tx,
         input logic signed [15:0] ty, input logic signed [16:0] tl);
      gaze_request_type r;
      r.mode = mode;
      r.px = px;
      r.py = py;
      r.sal = sal;
      r.frame_end = frame_end;
      r.tx = tx;
      r.ty = ty;
      r.tl = tl;
      return r;
   endfunction

   // every field random, the mode fixed by the caller
   function automatic gaze_request_type random_request(input logic [1:0] mode);
      return make_request(mode, 10'($urandom), 10'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom), 17'($urandom));
   endfunction

   function automatic gaze_request_type random_pixel(input logic frame_end);
      gaze_request_type r;
      r = random_request(spgs_pkg::MODE_PIXEL);
      if ($urandom_range(99) < 85) begin
         r.px = 10'($urandom_range(0, FRAME_W - 1));
         r.py = 10'($urandom_range(0, FRAME_H - 1));
      end
      case ($urandom_range(0, 3))
         0: r.sal = 16'($urandom_range(0, 8));
         1: r.sal = 16'($urandom_range(16'hC000, 16'hFFFF));
         default: ;
      endcase
      // a few broken frames: missing or early frame end
      r.frame_end = ($urandom_range(99) < 6) ? !frame_end : frame_end;
      return r;
   endfunction

   function automatic gaze_request_type random_tracker();
      gaze_request_type r;
      r = random_request(spgs_pkg::MODE_TRACKER);
      case ($urandom_range(0, 3))
         0, 1: r.tl = 17'($urandom_range(0, 511) - 256);
         2: r.tl = 17'h10000 | 17'($urandom_range(0, 16'hFFFF));
         default: ;
      endcase
      return r;
   endfunction

   // frames of pixels with ticks, tracker reports and the odd unused mode mixed in
   task automatic run_random_frames(input int n_items);
      int sent;
      int frame_len;
      sent = 0;
      while (sent < n_items) begin
         frame_len = $urandom_range(1, 12);
         for (int i = 0; i < frame_len; i++) begin
            send_request(random_pixel(i == frame_len - 1));
            sent++;
            if ($urandom_range(99) < 15) begin
               send_request(random_request(spgs_pkg::MODE_TICK));
               sent++;
            end
         end
         repeat ($urandom_range(1, 3)) begin
            send_request(random_request(spgs_pkg::MODE_TICK));
            sent++;
         end
         if ($urandom_range(99) < 30) begin
            send_request(random_tracker());
            sent++;
         end
         if ($urandom_range(99) < 4) send_request(random_request(MODE_UNUSED));
      end
   endtask

   // after reset: negligible held peak, tracker extremes, unused mode
   task automatic test_reset_state();
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(MODE_UNUSED, 10'h3FF, 10'h3FF, 16'hFFFF, 1, -1, -1, -1));
      send_request(make_request(spgs_pkg::MODE_TRACKER, 0, 0, 0, 0, -16'sd32768,
                                16'sd32767, -17'sd65536));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TRACKER, 0, 0, 0, 0, 16'sd32767,
                                -16'sd32768, 17'sd65535));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TRACKER, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TRACKER, 0, 0, 0, 0, 16'sd5, -16'sd5,
                                -17'sd1));
      wait_idle();
   endtask

   // peak choice, out-of-frame peak, jump, repeated jump, low peak, near peak
   task automatic test_peak_selection();
      write_register(spgs_pkg::REG_DELAY, 16'd0);
      write_register(REG_UNMAPPED, 16'hFFFF);
      send_request(make_request(spgs_pkg::MODE_PIXEL, 0, 0, 16'h0000, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_PIXEL, 10, 10, 16'h0100, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_PIXEL, 20, 20, 16'h0100, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_PIXEL, 10'h3FF, 10'h3FF, 16'hFFFF, 1,
                                0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_PIXEL, 100, 50, 16'h3000, 1, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_PIXEL, 300, 200, 16'h0002, 1, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_PIXEL, 299, 199, 16'h2000, 1, 0, 0, 0));
      send_request(make_request(spgs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_reset_settings();
      write_register(spgs_pkg::REG_DELAY, 16'd100);
      run_random_frames(100);
      wait_idle();
   endtask

   // lowest thresholds, zero delay, widest limits
   task automatic test_low_extremes();
      load_settings(16'd0, 10'd0, 16'd0, 11'd0, 11'd1024, 11'd0, 11'd1024, 1'b0);
      run_random_frames(150);
      wait_idle();
   endtask

   // highest thresholds, saturated delay, closed limits, saccade targets suppressed
   task automatic test_high_extremes();
      load_settings(16'hFFFF, 10'h3FF, 16'hFFFF, 11'd1024, 11'd0, 11'd1024, 11'd0, 1'b1);
      run_random_frames(100);
      wait_idle();
   endtask

   task automatic test_inhibit();
      load_settings(16'd1000, 10'd10, 16'd2, 11'd5, 11'd1000, 11'd5, 11'd1000, 1'b1);
      run_random_frames(100);
      wait_idle();
   endtask

   task automatic test_random_settings();
      repeat (5) begin
         load_random_settings();
         run_random_frames(100);
         wait_idle();
      end
   endtask

   // full rate on both sides
   task automatic test_full_rate();
      load_random_settings();
      steady <= 1'b1;
      run_random_frames(150);
      wait_idle();
      steady <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_mode          = spgs_pkg::MODE_PIXEL;
      req_pixel_x       = '0;
      req_pixel_y       = '0;
      req_salience      = '0;
      req_frame_last    = 1'b0;
      req_tracker_pos_x = '0;
      req_tracker_pos_y = '0;
      req_tracker_level = '0;
      rsp_ready         = 1'b0;
      steady            = 1'b0;
      failures          = 0;
      targets_checked   = 0;
      cycles            = 0;
      reset_selector();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_peak_selection();
      test_reset_settings();
      test_low_extremes();
      test_high_extremes();
      test_inhibit();
      test_random_settings();
      test_full_rate();

      $display("requests: %0d pixels, %0d tracker reports, %0d ticks, %0d unused mode",
               mode_counts[spgs_pkg::MODE_PIXEL], mode_counts[spgs_pkg::MODE_TRACKER],
               mode_counts[spgs_pkg::MODE_TICK], mode_counts[MODE_UNUSED]);
      $display("targets checked: %0d over reset, extreme and random settings, saccades: %0d",
               targets_checked, saccade_total);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
